[rtl/core/hrmc_pkg.sv]
// Shared types and constants for the half-duplex radio mode controller.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package hrmc_pkg;

   // Payload and timing limits
   localparam logic [7:0]  MaxPayload     = 8'd255;
   localparam logic [15:0] DefaultTimeout = 16'd3000;
   localparam logic [15:0] ElapsedMax     = 16'hFFFF;

   // Word widths on the stream ports
   localparam int ReqDataW = 48;
   localparam int RspDataW = 80;

   // Action codes
   localparam logic [2:0] ActSend   = 3'd0;
   localparam logic [2:0] ActRxOn   = 3'd1;
   localparam logic [2:0] ActRxOff  = 3'd2;
   localparam logic [2:0] ActIrq    = 3'd3;
   localparam logic [2:0] ActTick   = 3'd4;
   localparam logic [2:0] ActRdPkt  = 3'd5;
   localparam logic [2:0] ActRdCnt  = 3'd6;

   // Command flags
   localparam logic [3:0] CmdTx    = 4'b0001;
   localparam logic [3:0] CmdRx    = 4'b0010;
   localparam logic [3:0] CmdStby  = 4'b0100;
   localparam logic [3:0] CmdClose = 4'b1000;

   // Interrupt bit positions
   localparam int IrqTxDone   = 0;
   localparam int IrqRxDone   = 1;
   localparam int IrqPreamble = 2;
   localparam int IrqCrc      = 3;
   localparam int IrqHeader   = 4;
   localparam int IrqTimeout  = 5;

   // Event counter indexes
   localparam int NumCounters  = 10;
   localparam int CntTxStart   = 0;
   localparam int CntTxTimeout = 1;
   localparam int CntRxDone    = 2;
   localparam int CntRxOk      = 3;
   localparam int CntIrq       = 4;
   localparam int CntPreamble  = 5;
   localparam int CntCrc       = 6;
   localparam int CntHeader    = 7;
   localparam int CntTimeout   = 8;
   localparam int CntTxDone    = 9;

   // Configuration register indexes
   localparam logic CsrEnabled = 1'b0;
   localparam logic CsrTimeout = 1'b1;

   typedef struct packed {
      logic [3:0]        counter_select;
      logic signed [7:0] signal_rssi_in;
      logic signed [7:0] snr_in;
      logic signed [7:0] rssi_in;
      logic [5:0]        irq_bits;
      logic [7:0]        length;
      logic [2:0]        action;
   } req_type;

   typedef struct packed {
      logic [5:0]        recent_irq;
      logic [31:0]       counter_value;
      logic signed [7:0] pkt_signal_rssi;
      logic signed [7:0] pkt_snr;
      logic signed [7:0] pkt_rssi;
      logic [7:0]        pkt_length;
      logic              packet_ready;
      logic              rx_on;
      logic              busy_res;
      logic [3:0]        commands;
      logic              ok;
   } rsp_type;

endpackage

[rtl/core/hrmc_in_stage.sv]
// Input register of the mode controller: takes one request word and holds it.
// Depends on hrmc_pkg for the request layout.
`timescale 1ns / 1ps

module hrmc_in_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [hrmc_pkg::ReqDataW-1:0] req_tdata,
   input  logic                          dn_ready,
   output logic                          fire,
   output hrmc_pkg::req_type             item
);

   logic              valid_ff, valid_in;
   hrmc_pkg::req_type item_ff;
   logic              take;

   // Advance the held word when the result register can take it
   assign fire       = valid_ff & dn_ready;
   assign req_tready = ~valid_ff | dn_ready;
   assign take       = req_tvalid & req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload; unused pad bits drop here
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= hrmc_pkg::req_type'(req_tdata[$bits(hrmc_pkg::req_type)-1:0]);
      end
   end

   assign item = item_ff;

endmodule

[rtl/core/hrmc_ctrl.sv]
// Mode state, event counters and per-word decision logic of the controller.
// Depends on hrmc_pkg for action codes, flags, counter indexes and word types.
`timescale 1ns / 1ps

module hrmc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wen,
   input  logic              csr_index,
   input  logic [15:0]       csr_wdata,
   input  logic              fire,
   input  hrmc_pkg::req_type item,
   output hrmc_pkg::rsp_type rsp
);

   // Configuration
   logic        enabled_ff;
   logic [15:0] timeout_ff;

   // Mode state
   logic        tx_active_ff, tx_active_in;
   logic        rx_en_ff, rx_en_in;
   logic        resume_ff, resume_in;
   logic        pending_ff, pending_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  rssi_ff, snr_ff, sig_ff;
   logic        store_pkt;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [5:0]  recent_irq_ff, recent_irq_in;
   logic [31:0] cnt_ff [hrmc_pkg::NumCounters];
   logic [hrmc_pkg::NumCounters-1:0] bump;

   // Scratch
   logic [15:0] limit;
   logic [15:0] elapsed_next;
   logic        sel_ok;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         timeout_ff <= hrmc_pkg::DefaultTimeout;
      end else if (csr_wen) begin
         unique case (csr_index)
            hrmc_pkg::CsrEnabled: enabled_ff <= csr_wdata[0];
            hrmc_pkg::CsrTimeout: timeout_ff <= csr_wdata;
            default:              enabled_ff <= enabled_ff;
         endcase
      end
   end

   assign limit        = (timeout_ff == 16'd0) ? hrmc_pkg::DefaultTimeout : timeout_ff;
   assign elapsed_next = (elapsed_ff != hrmc_pkg::ElapsedMax) ? elapsed_ff + 16'd1 : elapsed_ff;
   assign sel_ok       = (item.counter_select < 4'(hrmc_pkg::NumCounters));

   // Decide the word: next state, counter bumps and result fields
   always_comb begin
      tx_active_in  = tx_active_ff;
      rx_en_in      = rx_en_ff;
      resume_in     = resume_ff;
      pending_in    = pending_ff;
      len_in        = len_ff;
      store_pkt     = 1'b0;
      elapsed_in    = elapsed_ff;
      recent_irq_in = recent_irq_ff;
      bump          = '0;
      rsp           = '0;

      unique case (item.action)
         hrmc_pkg::ActSend: begin
            if (enabled_ff && item.length != 8'd0 && item.length <= hrmc_pkg::MaxPayload
                && !tx_active_ff) begin
               resume_in                 = rx_en_ff;
               rx_en_in                  = 1'b0;
               tx_active_in              = 1'b1;
               elapsed_in                = 16'd0;
               bump[hrmc_pkg::CntTxStart] = 1'b1;
               rsp.commands              = hrmc_pkg::CmdTx;
               rsp.ok                    = 1'b1;
            end
         end
         hrmc_pkg::ActRxOn: begin
            if (enabled_ff && !tx_active_ff) begin
               resume_in    = 1'b0;
               rx_en_in     = 1'b1;
               rsp.commands = hrmc_pkg::CmdRx;
               rsp.ok       = 1'b1;
            end
         end
         hrmc_pkg::ActRxOff: begin
            if (enabled_ff) begin
               rsp.ok    = 1'b1;
               resume_in = 1'b0;
               if (!tx_active_ff) begin
                  rx_en_in     = 1'b0;
                  rsp.commands = hrmc_pkg::CmdStby | hrmc_pkg::CmdClose;
               end
            end
         end
         hrmc_pkg::ActIrq: begin
            if (enabled_ff && item.irq_bits != 6'd0) begin
               rsp.ok                       = 1'b1;
               recent_irq_in                = item.irq_bits;
               bump[hrmc_pkg::CntIrq]       = 1'b1;
               bump[hrmc_pkg::CntPreamble]  = item.irq_bits[hrmc_pkg::IrqPreamble];
               bump[hrmc_pkg::CntCrc]       = item.irq_bits[hrmc_pkg::IrqCrc];
               bump[hrmc_pkg::CntHeader]    = item.irq_bits[hrmc_pkg::IrqHeader];
               bump[hrmc_pkg::CntTimeout]   = item.irq_bits[hrmc_pkg::IrqTimeout];
               // Receive completion: keep a clean, non-empty packet
               if (item.irq_bits[hrmc_pkg::IrqRxDone]) begin
                  bump[hrmc_pkg::CntRxDone] = 1'b1;
                  if (!item.irq_bits[hrmc_pkg::IrqCrc] && !item.irq_bits[hrmc_pkg::IrqHeader]
                      && item.length != 8'd0) begin
                     len_in     = (item.length > hrmc_pkg::MaxPayload) ?
                                  hrmc_pkg::MaxPayload : item.length;
                     store_pkt  = 1'b1;
                     pending_in = 1'b1;
                     bump[hrmc_pkg::CntRxOk] = 1'b1;
                  end
                  if (rx_en_ff) begin
                     rsp.commands = rsp.commands | hrmc_pkg::CmdRx;
                  end
               end
               // Transmit completion: drop busy and resume receive if due
               if (item.irq_bits[hrmc_pkg::IrqTxDone]) begin
                  tx_active_in               = 1'b0;
                  bump[hrmc_pkg::CntTxDone]  = 1'b1;
                  if (resume_ff) begin
                     resume_in    = 1'b0;
                     rx_en_in     = 1'b1;
                     rsp.commands = rsp.commands | hrmc_pkg::CmdRx;
                  end else if (!rx_en_ff) begin
                     rsp.commands = rsp.commands | hrmc_pkg::CmdClose;
                  end
               end
            end
         end
         hrmc_pkg::ActTick: begin
            if (enabled_ff && tx_active_ff) begin
               elapsed_in = elapsed_next;
               // Abandon a transmission that ran past the limit
               if (elapsed_next > limit) begin
                  tx_active_in                 = 1'b0;
                  bump[hrmc_pkg::CntTxTimeout] = 1'b1;
                  rsp.ok                       = 1'b1;
                  if (resume_ff) begin
                     resume_in    = 1'b0;
                     rx_en_in     = 1'b1;
                     rsp.commands = hrmc_pkg::CmdRx;
                  end else if (!rx_en_ff) begin
                     rsp.commands = hrmc_pkg::CmdClose;
                  end
               end
            end
         end
         hrmc_pkg::ActRdPkt: begin
            if (enabled_ff && pending_ff) begin
               rsp.ok              = 1'b1;
               rsp.pkt_length      = len_ff;
               rsp.pkt_rssi        = rssi_ff;
               rsp.pkt_snr         = snr_ff;
               rsp.pkt_signal_rssi = sig_ff;
               pending_in          = 1'b0;
               len_in              = 8'd0;
            end
         end
         hrmc_pkg::ActRdCnt: begin
            if (sel_ok) begin
               rsp.ok            = 1'b1;
               rsp.counter_value = cnt_ff[item.counter_select];
            end
         end
         default: begin
            rsp.ok = 1'b0;
         end
      endcase

      rsp.busy_res     = tx_active_in;
      rsp.rx_on        = rx_en_in;
      rsp.packet_ready = pending_in;
      rsp.recent_irq   = recent_irq_in;
   end

   // Commit the state when the word moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_active_ff  <= 1'b0;
         rx_en_ff      <= 1'b0;
         resume_ff     <= 1'b0;
         pending_ff    <= 1'b0;
         len_ff        <= 8'd0;
         rssi_ff       <= 8'd0;
         snr_ff        <= 8'd0;
         sig_ff        <= 8'd0;
         elapsed_ff    <= 16'd0;
         recent_irq_ff <= 6'd0;
      end else if (fire) begin
         tx_active_ff  <= tx_active_in;
         rx_en_ff      <= rx_en_in;
         resume_ff     <= resume_in;
         pending_ff    <= pending_in;
         len_ff        <= len_in;
         elapsed_ff    <= elapsed_in;
         recent_irq_ff <= recent_irq_in;
         if (store_pkt) begin
            rssi_ff <= item.rssi_in;
            snr_ff  <= item.snr_in;
            sig_ff  <= item.signal_rssi_in;
         end
      end
   end

   // Advance the event counters; they wrap
   always_ff @(posedge clock) begin
      for (int i = 0; i < hrmc_pkg::NumCounters; i++) begin
         if (reset) begin
            cnt_ff[i] <= 32'd0;
         end else if (fire && bump[i]) begin
            cnt_ff[i] <= cnt_ff[i] + 32'd1;
         end
      end
   end

   a_send_starts_tx: assert property (@(posedge clock) disable iff (reset)
      fire && item.action == hrmc_pkg::ActSend && rsp.ok |=> tx_active_ff && elapsed_ff == 16'd0)
      else $error("accepted send did not start a transmission");

   a_tick_abandons: assert property (@(posedge clock) disable iff (reset)
      fire && item.action == hrmc_pkg::ActTick && rsp.ok |=> !tx_active_ff)
      else $error("timeout tick left the transmission active");

   a_read_clears: assert property (@(posedge clock) disable iff (reset)
      fire && item.action == hrmc_pkg::ActRdPkt && rsp.ok |=> !pending_ff && len_ff == 8'd0)
      else $error("packet read left a packet pending");

   a_disabled_refuses: assert property (@(posedge clock) disable iff (reset)
      fire && !enabled_ff && item.action != hrmc_pkg::ActRdCnt |-> !rsp.ok)
      else $error("request granted while disabled");

endmodule

[rtl/core/hrmc_out_stage.sv]
// Result register of the mode controller: holds one result word until taken.
// Depends on hrmc_pkg for the result layout.
`timescale 1ns / 1ps

module hrmc_out_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  hrmc_pkg::rsp_type             rsp,
   output logic                          dn_ready,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [hrmc_pkg::RspDataW-1:0] rsp_tdata
);

   logic              valid_ff, valid_in;
   hrmc_pkg::rsp_type rsp_ff;

   // Free when empty or when the held word leaves this cycle
   assign dn_ready = ~valid_ff | rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (fire) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(hrmc_pkg::RspDataW - $bits(hrmc_pkg::rsp_type)){1'b0}}, rsp_ff};

endmodule

[rtl/core/half_duplex_radio_mode_controller.sv]
// Half-duplex radio mode controller: one result word for every request word.
// Each request word passes the input register, then the result register; the result is held
// there until the result side takes it, and a full result register stalls the input.
// Throughput: one word per cycle, limited only by the result side taking words.
// Reset (synchronous, active high) clears mode state, counters and stored packet,
// disables the block and sets the transmit timeout to 3000 tick requests.
`timescale 1ns / 1ps

module half_duplex_radio_mode_controller (
   input  logic        clock,
   input  logic        reset,
   // Request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   // action[2:0], length[10:3], irq_bits[16:11], rssi_in[24:17], snr_in[32:25],
   // signal_rssi_in[40:33], counter_select[44:41], zero pad[47:45]
   input  logic [47:0] req_tdata,
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // ok[0], commands[4:1], busy_res[5], rx_on[6], packet_ready[7], pkt_length[15:8],
   // pkt_rssi[23:16], pkt_snr[31:24], pkt_signal_rssi[39:32], counter_value[71:40],
   // recent_irq[77:72], zero pad[79:78]
   output logic [79:0] rsp_tdata,
   // Configuration writes
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic              fire;
   logic              dn_ready;
   hrmc_pkg::req_type item;
   hrmc_pkg::rsp_type rsp;

   hrmc_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .dn_ready   (dn_ready),
      .fire       (fire),
      .item       (item)
   );

   hrmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fire      (fire),
      .item      (item),
      .rsp       (rsp)
   );

   hrmc_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .rsp        (rsp),
      .dn_ready   (dn_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
